// ----- rtl/core/ead_pkg.sv -----
package ead_pkg;

  localparam int ValW = 16;
  localparam int AngW = 16;
  localparam int HalfPiQ16 = 102944;
  localparam int HalfPiQ13 = 12868;
  localparam int AngleLimit = 25736;
  localparam int TableLen = 24;

  typedef struct packed {
    logic [3:0] yi;
    logic       yneg;
    logic [3:0] xi;
    logic       xneg;
  } pair_sel_t;

  typedef struct packed {
    logic [1:0] mid;
    logic [3:0] si;
    logic       sneg;
    logic [1:0] a1;
    pair_sel_t  t1;
    logic [1:0] a2;
    pair_sel_t  t2;
    pair_sel_t  tg;
  } order_desc_t;

  function automatic order_desc_t order_lookup(input logic [2:0] ord);
    order_desc_t o;
    case (ord)
      3'd1: o = '{2'd2, 4'd1, 1'b1, 2'd0, '{4'd7, 1'b0, 4'd4, 1'b0}, 2'd1,
                 '{4'd2, 1'b0, 4'd0, 1'b0}, '{4'd6, 1'b1, 4'd8, 1'b0}};
      3'd2: o = '{2'd0, 4'd5, 1'b1, 2'd1, '{4'd2, 1'b0, 4'd8, 1'b0}, 2'd2,
                 '{4'd3, 1'b0, 4'd4, 1'b0}, '{4'd1, 1'b1, 4'd0, 1'b0}};
      3'd3: o = '{2'd2, 4'd3, 1'b0, 2'd1, '{4'd6, 1'b1, 4'd0, 1'b0}, 2'd0,
                 '{4'd5, 1'b1, 4'd4, 1'b0}, '{4'd7, 1'b0, 4'd8, 1'b0}};
      3'd4: o = '{2'd0, 4'd7, 1'b0, 2'd2, '{4'd1, 1'b1, 4'd4, 1'b0}, 2'd1,
                 '{4'd6, 1'b1, 4'd8, 1'b0}, '{4'd2, 1'b0, 4'd0, 1'b0}};
      3'd5: o = '{2'd1, 4'd6, 1'b1, 2'd2, '{4'd3, 1'b0, 4'd0, 1'b0}, 2'd0,
                 '{4'd7, 1'b0, 4'd8, 1'b0}, '{4'd1, 1'b1, 4'd2, 1'b0}};
      default: o = '{2'd1, 4'd2, 1'b0, 2'd0, '{4'd5, 1'b1, 4'd8, 1'b0}, 2'd2,
                 '{4'd1, 1'b1, 4'd0, 1'b0}, '{4'd3, 1'b0, 4'd4, 1'b0}};
    endcase
    return o;
  endfunction

  function automatic logic [16:0] atan_entry(input int i);
    logic [16:0] r;
    case (i)
      0: r = 17'd51472;
      1: r = 17'd30386;
      2: r = 17'd16055;
      3: r = 17'd8150;
      4: r = 17'd4091;
      5: r = 17'd2047;
      6: r = 17'd1024;
      7: r = 17'd512;
      8: r = 17'd256;
      9: r = 17'd128;
      10: r = 17'd64;
      11: r = 17'd32;
      12: r = 17'd16;
      13: r = 17'd8;
      14: r = 17'd4;
      15: r = 17'd2;
      16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/euler_angle_decomposition_unit.sv -----
// Rotation matrix to Euler angles. Takes one Q1.14 3x3 matrix per cycle
// while the output is not stalled and returns angle_x/y/z in radians (13
// fraction bits) for the order held in the order register (0=XYZ .. 5=ZYX,
// 6/7 act as XYZ). A result passes through 16 sqrt pipeline stages, the
// CORDIC preload, CORDIC_STAGES stages, rounding and the output register,
// the first of them loaded at the accepting edge; the whole pipeline
// advances together, so a stalled output holds every stage.
// Gimbal lock (asin argument at or beyond +-1) zeros the third angle.
module euler_angle_decomposition_unit #(
  parameter int CORDIC_STAGES = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] rot_00,
  input  logic signed [15:0] rot_01,
  input  logic signed [15:0] rot_02,
  input  logic signed [15:0] rot_10,
  input  logic signed [15:0] rot_11,
  input  logic signed [15:0] rot_12,
  input  logic signed [15:0] rot_20,
  input  logic signed [15:0] rot_21,
  input  logic signed [15:0] rot_22,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] angle_x,
  output logic signed [15:0] angle_y,
  output logic signed [15:0] angle_z
);
  import ead_pkg::*;

  localparam int SqLat = 16;
  localparam int CLat = CORDIC_STAGES + 2;
  localparam int Lat = SqLat + CLat + 1;

  typedef struct packed {
    logic signed [17:0] y1, x1, y2, x2, yg, xg;
    logic [1:0] mid, a1, a2;
    logic gimbal, gneg;
  } ctl_t;

  localparam int CtlW = $bits(ctl_t);

  logic [2:0] order;
  logic en;
  logic [Lat-1:0] vld;
  logic signed [15:0] m [9];
  order_desc_t od;
  ctl_t c_in, c_sq, c_d [CLat];
  logic signed [16:0] s_raw, s_sat, s_sq;
  logic [15:0] root;
  logic signed [15:0] ang_mid, ang_1, ang_2;
  logic signed [15:0] res [3];
  logic signed [15:0] a1v;

  always_ff @(posedge clk) begin
    if (rst) order <= '0;
    else if (cfg_we) order <= cfg_wdata;
  end

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], in_valid};
  end

  assign m[0] = rot_00; assign m[1] = rot_01; assign m[2] = rot_02;
  assign m[3] = rot_10; assign m[4] = rot_11; assign m[5] = rot_12;
  assign m[6] = rot_20; assign m[7] = rot_21; assign m[8] = rot_22;

  function automatic logic signed [17:0] pick(input logic signed [15:0] v,
                                               input logic neg);
    logic signed [17:0] e;
    e = 18'(v);
    return neg ? -e : e;
  endfunction

  always_comb begin
    od = order_lookup(order > 3'd5 ? 3'd0 : order);
    s_raw = od.sneg ? -17'(m[od.si]) : 17'(m[od.si]);
    s_sat = s_raw;
    if (s_raw > 17'sd16384) s_sat = 17'sd16384;
    if (s_raw < -17'sd16384) s_sat = -17'sd16384;
    c_in.y1 = pick(m[od.t1.yi], od.t1.yneg);
    c_in.x1 = pick(m[od.t1.xi], od.t1.xneg);
    c_in.y2 = pick(m[od.t2.yi], od.t2.yneg);
    c_in.x2 = pick(m[od.t2.xi], od.t2.xneg);
    c_in.yg = pick(m[od.tg.yi], od.tg.yneg);
    c_in.xg = pick(m[od.tg.xi], od.tg.xneg);
    c_in.mid = od.mid;
    c_in.a1 = od.a1;
    c_in.a2 = od.a2;
    c_in.gimbal = (s_sat == 17'sd16384) || (s_sat == -17'sd16384);
    c_in.gneg = s_sat < 0;
  end

  ead_isqrt #(.W(CtlW)) u_sqrt (
    .clk(clk), .en(en), .tag_in(c_in), .s_in(s_sat),
    .tag_out(c_sq), .s_out(s_sq), .root(root)
  );

  ead_cordic #(.STAGES(CORDIC_STAGES)) u_mid (
    .clk(clk), .en(en), .yv(18'(s_sq)), .xv(18'({2'b00, root})), .angle(ang_mid)
  );
  ead_cordic #(.STAGES(CORDIC_STAGES)) u_a1 (
    .clk(clk), .en(en), .yv(c_sq.gimbal ? c_sq.yg : c_sq.y1),
    .xv(c_sq.gimbal ? c_sq.xg : c_sq.x1), .angle(ang_1)
  );
  ead_cordic #(.STAGES(CORDIC_STAGES)) u_a2 (
    .clk(clk), .en(en), .yv(c_sq.y2), .xv(c_sq.x2), .angle(ang_2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      c_d[0] <= c_sq;
      for (int k = 1; k < CLat; k++) c_d[k] <= c_d[k-1];
    end
  end

  always_comb begin
    res[0] = '0; res[1] = '0; res[2] = '0;
    a1v = (c_d[CLat-1].gimbal && c_d[CLat-1].gneg) ? -ang_1 : ang_1;
    res[c_d[CLat-1].a1] = a1v;
    res[c_d[CLat-1].a2] = c_d[CLat-1].gimbal ? 16'sd0 : ang_2;
    // gimbal lock gives exactly +-pi/2 for the middle angle
    if (!c_d[CLat-1].gimbal) res[c_d[CLat-1].mid] = ang_mid;
    else if (c_d[CLat-1].gneg) res[c_d[CLat-1].mid] = -16'(HalfPiQ13);
    else res[c_d[CLat-1].mid] = 16'(HalfPiQ13);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_x <= res[0];
      angle_y <= res[1];
      angle_z <= res[2];
    end
  end

  a_rdy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("ready while output stalled");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle_x) && $stable(angle_z))
    else $error("result changed while stalled");
  a_vld: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");
endmodule

// ----- rtl/core/ead_isqrt.sv -----
module ead_isqrt #(
  parameter int W = 4
) (
  input  logic                clk,
  input  logic                en,
  input  logic [W-1:0]        tag_in,
  input  logic signed [16:0]  s_in,
  output logic [W-1:0]        tag_out,
  output logic signed [16:0]  s_out,
  output logic [15:0]         root
);
  // one result bit per stage, 15 stages, n = 2^28 - s*s
  localparam int Steps = 15;
  logic [28:0] n_q [Steps+1];
  logic [28:0] r_q [Steps+1];
  logic [W-1:0] t_q [Steps+1];
  logic signed [16:0] s_q [Steps+1];
  logic signed [33:0] sq;

  assign sq = s_in * s_in;

  always_ff @(posedge clk) begin
    if (en) begin
      n_q[0] <= 29'(34'sd268435456 - sq);
      r_q[0] <= '0;
      t_q[0] <= tag_in;
      s_q[0] <= s_in;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_st
    localparam logic [28:0] Bit = 29'(1) << (28 - 2 * k);
    always_ff @(posedge clk) begin
      if (en) begin
        if (n_q[k] >= r_q[k] + Bit) begin
          n_q[k+1] <= n_q[k] - (r_q[k] + Bit);
          r_q[k+1] <= (r_q[k] >> 1) + Bit;
        end else begin
          n_q[k+1] <= n_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
        t_q[k+1] <= t_q[k];
        s_q[k+1] <= s_q[k];
      end
    end
  end

  assign root = r_q[Steps][15:0];
  assign tag_out = t_q[Steps];
  assign s_out = s_q[Steps];
endmodule

// ----- rtl/core/ead_cordic.sv -----
module ead_cordic #(
  parameter int STAGES = 14
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [17:0] yv,
  input  logic signed [17:0] xv,
  output logic signed [15:0] angle
);
  import ead_pkg::*;
  // values carried unscaled with 16 fraction bits appended
  localparam int DW = 38;
  localparam int ZW = 20;
  logic signed [DW-1:0] x_q [STAGES+1];
  logic signed [DW-1:0] y_q [STAGES+1];
  logic signed [ZW-1:0] z_q [STAGES+1];
  logic zero_q [STAGES+1];
  logic signed [DW-1:0] x0, y0;
  logic signed [ZW-1:0] z0, zr, zf;

  always_comb begin
    x0 = {{(DW-34){xv[17]}}, xv, 16'd0};
    y0 = {{(DW-34){yv[17]}}, yv, 16'd0};
    z0 = '0;
    if (xv < 0) begin
      if (yv >= 0) begin
        x0 = {{(DW-34){yv[17]}}, yv, 16'd0};
        y0 = -{{(DW-34){xv[17]}}, xv, 16'd0};
        z0 = ZW'(HalfPiQ16);
      end else begin
        x0 = -{{(DW-34){yv[17]}}, yv, 16'd0};
        y0 = {{(DW-34){xv[17]}}, xv, 16'd0};
        z0 = -ZW'(HalfPiQ16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0] <= x0;
      y_q[0] <= y0;
      z_q[0] <= z0;
      zero_q[0] <= (xv == 0) && (yv == 0);
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    localparam logic signed [ZW-1:0] A = ZW'(atan_entry(i));
    localparam int Sh = (i > DW - 1) ? DW - 1 : i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> Sh);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> Sh);
          z_q[i+1] <= z_q[i] + A;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> Sh);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> Sh);
          z_q[i+1] <= z_q[i] - A;
        end
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  always_comb begin
    zf = zero_q[STAGES] ? '0 : z_q[STAGES];
    if (zf < 0) zr = -((-zf + 20'sd4) >>> 3);
    else zr = (zf + 20'sd4) >>> 3;
    if (zr > AngleLimit) zr = ZW'(AngleLimit);
    if (zr < -AngleLimit) zr = -ZW'(AngleLimit);
  end

  always_ff @(posedge clk) begin
    if (en) angle <= zr[15:0];
  end
endmodule
